// ===== src/ple_pkg.sv =====
package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int BIT_W    = $clog2(DATA_W);
    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [KIND_W-1:0] K_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] K_REMOVE  = 3'd1;
    localparam logic [KIND_W-1:0] K_DUMP    = 3'd2;
    localparam logic [KIND_W-1:0] K_MOVE    = 3'd3;
    localparam logic [KIND_W-1:0] K_REVERSE = 3'd4;
    localparam logic [KIND_W-1:0] K_ROTL    = 3'd5;
    localparam logic [KIND_W-1:0] K_ROTR    = 3'd6;

    localparam logic [1:0] PH_LAST   = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_FIRST  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP_RD,
        ST_DUMP_LD,
        ST_INS_CHK,
        ST_INS_WR,
        ST_REM_CHK,
        ST_REM_WR,
        ST_MV_RD,
        ST_MV_CAP,
        ST_MOD,
        ST_ROT_SET,
        ST_REV_CHK,
        ST_REV_R2,
        ST_REV_W1,
        ST_REV_W2
    } state_t;

endpackage

// ===== src/ple_ram.sv =====
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/positional_list_engine.sv =====
// Positional list engine: holds an ordered list of up to 32 signed values in a single
// element RAM (one write and one registered read per cycle) and runs one command per
// transaction. Insert, remove and move shift entries one at a time, each with a read and
// then a write; move first removes and then inserts. Reverse swaps entry pairs with two
// reads and two writes per pair. Rotate first reduces the amount modulo the count with a
// bit-serial unit, then, unless the reduced amount is zero, performs three range reversals.
// A dump emits one result transaction per element, reading the next element only after the
// previous result has left the output register. Error and empty-dump commands produce a
// single result with the list untouched. A new command is taken only after the previous
// one finishes, while a pending result may still wait on the output register.
module positional_list_engine (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ple_pkg::KIND_W-1:0]           s_kind,
    input  logic signed [ple_pkg::DATA_W-1:0]    s_value,
    input  logic [ple_pkg::POS_W-1:0]            s_pos_a,
    input  logic [ple_pkg::POS_W-1:0]            s_pos_b,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ple_pkg::DATA_W-1:0]    m_item,
    output logic                                 m_last,
    output logic                                 m_empty_res,
    output logic                                 m_error
);

    localparam int AW = ple_pkg::ADDR_W;
    localparam int CW = ple_pkg::CNT_W;
    localparam int DW = ple_pkg::DATA_W;
    localparam int PW = ple_pkg::POS_W;
    localparam int BW = ple_pkg::BIT_W;

    ple_pkg::state_t state_reg, state_next;

    logic [ple_pkg::KIND_W-1:0] kind_reg;
    logic [DW-1:0]              val_reg, val_next;
    logic [PW-1:0]              pa_reg, pb_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              lo_reg, lo_next;
    logic [AW-1:0]              hi_reg, hi_next;
    logic [AW-1:0]              rot_reg, rot_next;
    logic [CW-1:0]              rem_reg, rem_next;
    logic [BW-1:0]              bit_reg, bit_next;
    logic [1:0]                 ph_reg, ph_next;
    logic [DW-1:0]              hold_reg, hold_next;

    logic          m_valid_reg, m_valid_next;
    logic [DW-1:0] m_item_reg, m_item_next;
    logic          m_last_reg, m_last_next;
    logic          m_empty_reg, m_empty_next;
    logic          m_error_reg, m_error_next;
    logic          out_load;
    logic          out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic          s_fire;
    logic          exec_err;
    logic          exec_empty;
    logic          exec_nop;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] count_dec;
    logic [CW:0]   mod_shift;
    logic [CW:0]   mod_sub;
    logic [CW-1:0] mod_step;
    logic [CW-1:0] rot_amt;
    logic          rem_more;
    logic          ins_more;
    logic          dump_end;

    ple_ram #(
        .WIDTH(DW),
        .DEPTH(ple_pkg::CAPACITY)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign s_ready  = (state_reg == ple_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign rem_more  = idx_inc < count_reg;
    assign ins_more  = idx_reg > pos_reg;
    assign dump_end  = idx_inc == count_reg;

    assign mod_shift = {rem_reg, val_reg[bit_reg]};
    assign mod_sub   = mod_shift - {1'b0, count_reg};
    assign mod_step  = (mod_shift >= {1'b0, count_reg}) ? mod_sub[CW-1:0] : mod_shift[CW-1:0];
    assign rot_amt   = (kind_reg == ple_pkg::K_ROTL) ? rem_reg : (count_reg - rem_reg);

    always_comb begin
        exec_err = 1'b0;
        exec_nop = 1'b0;
        unique case (kind_reg)
            ple_pkg::K_INSERT: begin
                exec_err = (count_reg >= ple_pkg::CAP_CNT) || (pa_reg > count_reg);
            end
            ple_pkg::K_REMOVE: begin
                exec_nop = (count_reg == '0);
                exec_err = !exec_nop && (pa_reg >= count_reg);
            end
            ple_pkg::K_DUMP: begin
                exec_err = 1'b0;
            end
            ple_pkg::K_MOVE: begin
                exec_nop = (count_reg == '0);
                exec_err = !exec_nop && ((pa_reg >= count_reg) || (pb_reg >= count_reg));
            end
            ple_pkg::K_REVERSE: begin
                exec_nop = (count_reg < CW'(2));
            end
            ple_pkg::K_ROTL, ple_pkg::K_ROTR: begin
                exec_nop = (count_reg == '0);
                exec_err = !exec_nop && val_reg[DW-1];
            end
            default: begin
                exec_err = 1'b1;
            end
        endcase
        exec_empty = (kind_reg == ple_pkg::K_DUMP) && (count_reg == '0);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = ple_pkg::ST_EXEC;
                end
            end
            ple_pkg::ST_EXEC: begin
                if (exec_err || exec_empty) begin
                    if (out_free) begin
                        state_next = ple_pkg::ST_IDLE;
                    end
                end else if (exec_nop) begin
                    state_next = ple_pkg::ST_IDLE;
                end else begin
                    unique case (kind_reg)
                        ple_pkg::K_INSERT:            state_next = ple_pkg::ST_INS_CHK;
                        ple_pkg::K_REMOVE:            state_next = ple_pkg::ST_REM_CHK;
                        ple_pkg::K_DUMP:              state_next = ple_pkg::ST_DUMP_RD;
                        ple_pkg::K_MOVE:              state_next = ple_pkg::ST_MV_RD;
                        ple_pkg::K_REVERSE:           state_next = ple_pkg::ST_REV_CHK;
                        ple_pkg::K_ROTL, ple_pkg::K_ROTR: state_next = ple_pkg::ST_MOD;
                        default:                      state_next = ple_pkg::ST_IDLE;
                    endcase
                end
            end
            ple_pkg::ST_DUMP_RD: begin
                if (!m_valid_reg) begin
                    state_next = ple_pkg::ST_DUMP_LD;
                end
            end
            ple_pkg::ST_DUMP_LD: begin
                state_next = dump_end ? ple_pkg::ST_IDLE : ple_pkg::ST_DUMP_RD;
            end
            ple_pkg::ST_INS_CHK: begin
                state_next = ins_more ? ple_pkg::ST_INS_WR : ple_pkg::ST_IDLE;
            end
            ple_pkg::ST_INS_WR: begin
                state_next = ple_pkg::ST_INS_CHK;
            end
            ple_pkg::ST_REM_CHK: begin
                if (rem_more) begin
                    state_next = ple_pkg::ST_REM_WR;
                end else if (kind_reg == ple_pkg::K_MOVE) begin
                    state_next = ple_pkg::ST_INS_CHK;
                end else begin
                    state_next = ple_pkg::ST_IDLE;
                end
            end
            ple_pkg::ST_REM_WR: begin
                state_next = ple_pkg::ST_REM_CHK;
            end
            ple_pkg::ST_MV_RD: begin
                state_next = ple_pkg::ST_MV_CAP;
            end
            ple_pkg::ST_MV_CAP: begin
                state_next = ple_pkg::ST_REM_CHK;
            end
            ple_pkg::ST_MOD: begin
                if (bit_reg == '0) begin
                    state_next = ple_pkg::ST_ROT_SET;
                end
            end
            ple_pkg::ST_ROT_SET: begin
                state_next = (rem_reg == '0) ? ple_pkg::ST_IDLE : ple_pkg::ST_REV_CHK;
            end
            ple_pkg::ST_REV_CHK: begin
                if (lo_reg < hi_reg) begin
                    state_next = ple_pkg::ST_REV_R2;
                end else if (ph_reg == ple_pkg::PH_LAST) begin
                    state_next = ple_pkg::ST_IDLE;
                end
            end
            ple_pkg::ST_REV_R2: begin
                state_next = ple_pkg::ST_REV_W1;
            end
            ple_pkg::ST_REV_W1: begin
                state_next = ple_pkg::ST_REV_W2;
            end
            ple_pkg::ST_REV_W2: begin
                state_next = ple_pkg::ST_REV_CHK;
            end
            default: begin
                state_next = ple_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        val_next     = val_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        rot_next     = rot_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        ph_next      = ph_reg;
        hold_next    = hold_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[AW-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg[AW-1:0];
        out_load     = 1'b0;
        m_item_next  = ram_rdata;
        m_last_next  = 1'b1;
        m_empty_next = 1'b0;
        m_error_next = 1'b0;
        unique case (state_reg)
            ple_pkg::ST_IDLE: begin
                if (s_fire) begin
                    val_next = s_value;
                end
            end
            ple_pkg::ST_EXEC: begin
                if (exec_err || exec_empty) begin
                    out_load     = out_free;
                    m_item_next  = exec_err ? '0 : '1;
                    m_empty_next = !exec_err;
                    m_error_next = exec_err;
                end else begin
                    lo_next  = '0;
                    hi_next  = count_dec[AW-1:0];
                    ph_next  = ple_pkg::PH_LAST;
                    rem_next = '0;
                    bit_next = BW'(DW - 2);
                    idx_next = (kind_reg == ple_pkg::K_INSERT) ? count_reg
                             : (kind_reg == ple_pkg::K_DUMP)   ? '0
                             : pa_reg[CW-1:0];
                    pos_next = pa_reg[CW-1:0];
                end
            end
            ple_pkg::ST_DUMP_RD: begin
                ram_re = !m_valid_reg;
            end
            ple_pkg::ST_DUMP_LD: begin
                out_load    = 1'b1;
                m_last_next = dump_end;
                idx_next    = idx_inc;
            end
            ple_pkg::ST_INS_CHK: begin
                if (ins_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[AW-1:0];
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            ple_pkg::ST_INS_WR: begin
                ram_we   = 1'b1;
                idx_next = idx_dec;
            end
            ple_pkg::ST_REM_CHK: begin
                if (rem_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc[AW-1:0];
                end else begin
                    count_next = count_dec;
                    idx_next   = count_dec;
                    pos_next   = pb_reg[CW-1:0];
                end
            end
            ple_pkg::ST_REM_WR: begin
                ram_we   = 1'b1;
                idx_next = idx_inc;
            end
            ple_pkg::ST_MV_RD: begin
                ram_re = 1'b1;
            end
            ple_pkg::ST_MV_CAP: begin
                val_next = ram_rdata;
            end
            ple_pkg::ST_MOD: begin
                rem_next = mod_step;
                bit_next = bit_reg - 1'b1;
            end
            ple_pkg::ST_ROT_SET: begin
                rot_next = rot_amt[AW-1:0];
                lo_next  = '0;
                hi_next  = rot_amt[AW-1:0] - 1'b1;
                ph_next  = ple_pkg::PH_FIRST;
            end
            ple_pkg::ST_REV_CHK: begin
                if (lo_reg < hi_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = lo_reg;
                end else begin
                    unique case (ph_reg)
                        ple_pkg::PH_FIRST: begin
                            lo_next = rot_reg;
                            hi_next = count_dec[AW-1:0];
                            ph_next = ple_pkg::PH_SECOND;
                        end
                        ple_pkg::PH_SECOND: begin
                            lo_next = '0;
                            hi_next = count_dec[AW-1:0];
                            ph_next = ple_pkg::PH_LAST;
                        end
                        default: begin
                            ph_next = ple_pkg::PH_LAST;
                        end
                    endcase
                end
            end
            ple_pkg::ST_REV_R2: begin
                ram_re    = 1'b1;
                ram_raddr = hi_reg;
                hold_next = ram_rdata;
            end
            ple_pkg::ST_REV_W1: begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg;
            end
            ple_pkg::ST_REV_W2: begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = hold_reg;
                lo_next   = lo_reg + 1'b1;
                hi_next   = hi_reg - 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ple_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg <= s_kind;
            pa_reg   <= s_pos_a;
            pb_reg   <= s_pos_b;
        end
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        rot_reg  <= rot_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
        ph_reg   <= ph_next;
        hold_reg <= hold_next;
        if (out_load) begin
            m_item_reg  <= m_item_next;
            m_last_reg  <= m_last_next;
            m_empty_reg <= m_empty_next;
            m_error_reg <= m_error_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_item      = m_item_reg;
    assign m_last      = m_last_reg;
    assign m_empty_res = m_empty_reg;
    assign m_error     = m_error_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ple_pkg::CAP_CNT)
        else $error("Element count exceeds capacity.");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("Result register loaded while a transaction is pending.");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ple_pkg::ST_EXEC))
        else $error("Accepted command was not decoded.");

    a_swap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ple_pkg::ST_REV_W2) |-> (lo_reg < hi_reg))
        else $error("Swap issued with crossed bounds.");

endmodule
